// ===== sv/crs_pkg.sv =====
package crs_pkg;

    localparam int unsigned CoordW  = 16;
    localparam int unsigned RadiusW = 15;
    localparam int unsigned CurXW   = 17;
    localparam int unsigned CurYW   = 16;
    localparam int unsigned ErrW    = 19;
    localparam int unsigned PixelW  = 17;
    localparam int unsigned DimW    = 13;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned BurstN  = 4;

    localparam logic [DimW-1:0] WidthReset  = 13'd640;
    localparam logic [DimW-1:0] HeightReset = 13'd480;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_RASTER_WIDTH  = 1'b0,
        CFG_RASTER_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

endpackage

// ===== sv/circle_raster_stepper.sv =====
// Incremental midpoint circle rasterizer.
// Input channel (i_in_valid / o_in_stall): a start word (op 0) loads the center and
// radius and gives no output; a step word (op 1) gives the four symmetric pixels of
// the current iteration and advances the circle. A step word while no circle is
// running gives nothing.
// Output channel (o_out_valid / i_out_stall): one pixel per word with its in-bounds
// flag, o_last on the fourth pixel and o_done_res on all four pixels of the step
// that ends the circle.
// The first pixel of a step is valid in the cycle after the step word is accepted.
// The single output port carries the four pixels of a step one after another; the
// next word is accepted in the same cycle the fourth pixel is taken, so back-to-back
// steps sustain one pixel per cycle while the receiver does not stall. Start words
// and idle steps are accepted without a stall when no pixels are pending.
// Configuration writes (i_cfg_we) set the raster width and height and must be made
// while the block is idle.
// When the receiver stalls, the pending pixel holds and the input stalls until the
// last pixel of the step is taken. Reset empties the output, drops any running
// circle and sets the raster to 640 by 480.
module circle_raster_stepper (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [crs_pkg::CfgIdxW-1:0]           i_cfg_index,
    input  logic [crs_pkg::DimW-1:0]              i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_op,
    input  logic signed [crs_pkg::CoordW-1:0]     i_center_x,
    input  logic signed [crs_pkg::CoordW-1:0]     i_center_y,
    input  logic [crs_pkg::RadiusW-1:0]           i_radius,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [crs_pkg::PixelW-1:0]     o_pixel_x,
    output logic signed [crs_pkg::PixelW-1:0]     o_pixel_y,
    output logic                                  o_in_bounds,
    output logic                                  o_last,
    output logic                                  o_done_res
);
    import crs_pkg::*;

    localparam int unsigned WideW = 20;
    localparam int unsigned PixW  = 18;
    localparam int unsigned CntW  = $clog2(BurstN);

    logic [DimW-1:0]            r_width;
    logic [DimW-1:0]            r_height;
    logic signed [CurXW-1:0]    r_cur_x;
    logic [CurYW-1:0]           r_cur_y;
    logic signed [ErrW-1:0]     r_err;
    logic signed [CoordW-1:0]   r_center_col;
    logic signed [CoordW-1:0]   r_center_row;
    logic                       r_active;
    logic                       r_out_valid;
    logic [CntW-1:0]            r_cnt;
    logic                       r_done;
    logic signed [PixelW-1:0]   r_px [BurstN];
    logic signed [PixelW-1:0]   r_py [BurstN];
    logic                       r_inb [BurstN];

    logic                       in_acc;
    logic                       out_acc;
    logic                       out_last;
    logic                       step_go;
    logic signed [WideW-1:0]    e20;
    logic signed [WideW-1:0]    x20;
    logic signed [WideW-1:0]    y20;
    logic                       y_up;
    logic signed [WideW-1:0]    y1;
    logic signed [WideW-1:0]    e1;
    logic                       x_up;
    logic signed [WideW-1:0]    x1;
    logic signed [WideW-1:0]    e2;
    logic                       n_done;
    logic signed [PixW-1:0]     cc;
    logic signed [PixW-1:0]     cr;
    logic signed [PixW-1:0]     xs;
    logic signed [PixW-1:0]     ys;
    logic signed [PixW-1:0]     n_px [BurstN];
    logic signed [PixW-1:0]     n_py [BurstN];

    function automatic logic is_inside(input logic signed [PixW-1:0] px,
                                       input logic signed [PixW-1:0] py,
                                       input logic [DimW-1:0] w,
                                       input logic [DimW-1:0] h);
        logic signed [PixW-1:0] ws;
        logic signed [PixW-1:0] hs;
        ws = signed'({{(PixW-DimW){1'b0}}, w});
        hs = signed'({{(PixW-DimW){1'b0}}, h});
        return (px >= 0) && (px < ws) && (py >= 0) && (py < hs);
    endfunction

    assign out_last   = (r_cnt == CntW'(BurstN - 1));
    assign out_acc    = r_out_valid && !i_out_stall;
    assign o_in_stall = r_out_valid && !(out_acc && out_last);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign step_go    = in_acc && (t_op'(i_op) == OP_STEP) && r_active;

    always_comb begin
        e20    = WideW'(r_err);
        x20    = WideW'(r_cur_x);
        y20    = signed'({{(WideW-CurYW){1'b0}}, r_cur_y});
        y_up   = (e20 <= y20);
        y1     = y_up ? y20 + WideW'(1) : y20;
        e1     = y_up ? e20 + (y1 <<< 1) + WideW'(1) : e20;
        x_up   = (e20 > x20) || (e1 > y1);
        x1     = x_up ? x20 + WideW'(1) : x20;
        e2     = x_up ? e1 + (x1 <<< 1) + WideW'(1) : e1;
        n_done = (x1 >= 0);

        cc = PixW'(r_center_col);
        cr = PixW'(r_center_row);
        xs = PixW'(r_cur_x);
        ys = signed'({{(PixW-CurYW){1'b0}}, r_cur_y});
        n_px[0] = cc - xs;
        n_py[0] = cr + ys;
        n_px[1] = cc - ys;
        n_py[1] = cr - xs;
        n_px[2] = cc + xs;
        n_py[2] = cr - ys;
        n_px[3] = cc + ys;
        n_py[3] = cr + xs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= WidthReset;
            r_height     <= HeightReset;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_err        <= '0;
            r_center_col <= '0;
            r_center_row <= '0;
            r_active     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_done       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_RASTER_WIDTH:  r_width  <= i_cfg_data;
                    CFG_RASTER_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_acc && !step_go) begin
                r_cnt <= r_cnt + CntW'(1);
                if (out_last) begin
                    r_out_valid <= 1'b0;
                end
            end
            if (in_acc) begin
                if (t_op'(i_op) == OP_START) begin
                    r_center_col <= i_center_x;
                    r_center_row <= i_center_y;
                    r_cur_x      <= -CurXW'(signed'({2'b00, i_radius}));
                    r_cur_y      <= '0;
                    r_err        <= ErrW'(2) - ErrW'({i_radius, 1'b0});
                    r_active     <= 1'b1;
                end else if (r_active) begin
                    r_cur_x     <= CurXW'(x1);
                    r_cur_y     <= CurYW'(y1);
                    r_err       <= ErrW'(e2);
                    r_out_valid <= 1'b1;
                    r_cnt       <= '0;
                    r_done      <= n_done;
                    if (n_done) begin
                        r_active <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            for (int k = 0; k < BurstN; k++) begin
                r_px[k]  <= PixelW'(n_px[k]);
                r_py[k]  <= PixelW'(n_py[k]);
                r_inb[k] <= is_inside(n_px[k], n_py[k], r_width, r_height);
            end
        end else if (out_acc) begin
            for (int k = 0; k < BurstN - 1; k++) begin
                r_px[k]  <= r_px[k+1];
                r_py[k]  <= r_py[k+1];
                r_inb[k] <= r_inb[k+1];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_x   = r_px[0];
    assign o_pixel_y   = r_py[0];
    assign o_in_bounds = r_inb[0];
    assign o_last      = out_last;
    assign o_done_res  = r_done;

    a_burst_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && out_last && !in_acc |=> !o_out_valid)
        else $error("output stayed valid after the last pixel of a step");

    a_burst_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !out_last |=> o_out_valid && r_cnt == $past(r_cnt) + CntW'(1))
        else $error("pixel count did not advance within a step");

    a_done_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !out_last |=> o_done_res == $past(o_done_res))
        else $error("done flag changed within a step");

    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_go |=> o_out_valid && r_cnt == '0)
        else $error("active step did not start a pixel burst");

endmodule
